[rtl/pwf_pkg.sv]
package pwf_pkg;

  // Table depth and rotation count of the bearing unit.
  localparam int WAYPOINT_DEPTH = 64;
  localparam int CORDIC_STEPS   = 16;
  localparam int ADDR_W         = $clog2(WAYPOINT_DEPTH);
  localparam int STEP_W         = $clog2(CORDIC_STEPS + 1);
  localparam int ATAN_LEN       = 24;

  // Field widths.
  localparam int POS_W = 24;
  localparam int ANG_W = 16;
  localparam int IDX_W = 7;
  localparam int DIF_W = POS_W + 1;      // waypoint minus robot position
  localparam int SQ_W  = 2 * DIF_W;      // dx*dx + dy*dy
  localparam int RHO_W = DIF_W;          // floor square root of the sum
  localparam int XY_W  = DIF_W + 27;     // rotator x and y, inputs scaled by 2^24
  localparam int Z_W   = 34;             // rotator angle, units of 2^-30 rad

  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam int PI_Q12     = 12868;
  localparam int TWO_PI_Q12 = 25736;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_GAIN_DIST    = 3'd0;
  localparam logic [2:0] REG_GAIN_BEAR    = 3'd1;
  localparam logic [2:0] REG_GAIN_HEAD    = 3'd2;
  localparam logic [2:0] REG_ARRIVE_RAD   = 3'd3;
  localparam logic [2:0] REG_LINEAR_LIM   = 3'd4;
  localparam logic [2:0] REG_ANGULAR_LIM  = 3'd5;
  localparam logic [2:0] REG_WAYPOINT_CNT = 3'd6;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POSE = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [5:0]              entry_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [ANG_W-1:0] heading;
  } req_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0] v_cmd;
    logic signed [POS_W-1:0] w_cmd;
    logic [IDX_W-1:0]        target_index;
    logic                    reached;
    logic                    finished;
  } cmd_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SUMSQ,
    ST_ROOT_GO,
    ST_SOLVE,
    ST_ANGLE,
    ST_WRAP,
    ST_MRHO,
    ST_MALPHA,
    ST_MBETA,
    ST_SUMW,
    ST_RESULT
  } state_t;

  // Arctangent of 2^-i in units of 2^-30 rad.
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:  r = 34'sd843314856;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043836;
      5'd3:  r = 34'sd133525158;
      5'd4:  r = 34'sd67021686;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775850;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194282;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/pwf_isqrt.sv]
module pwf_isqrt
  import pwf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SQ_W-1:0]  radicand,
  output logic             busy,
  output logic [RHO_W-1:0] root
);

  // Two radicand bits enter the remainder each cycle, one root bit leaves.
  localparam int REM_W = RHO_W + 4;

  logic [SQ_W-1:0]  rad;
  logic [REM_W-1:0] rem;
  logic [4:0]       count;
  logic [REM_W-1:0] rem_shift;
  logic [REM_W-1:0] trial;
  logic             fits;

  assign rem_shift = {rem[REM_W-3:0], rad[SQ_W-1 -: 2]};
  assign trial     = {2'b00, root, 2'b01};
  assign fits      = rem_shift >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 5'(RHO_W - 1);
      rad   <= radicand;
      rem   <= '0;
      root  <= '0;
    end else if (busy) begin
      rad  <= {rad[SQ_W-3:0], 2'b00};
      rem  <= fits ? rem_shift - trial : rem_shift;
      root <= {root[RHO_W-2:0], fits};
      if (count == '0) begin
        busy <= 1'b0;
      end
      count <= count - 5'd1;
    end
  end

endmodule

[rtl/pwf_cordic.sv]
module pwf_cordic
  import pwf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DIF_W-1:0] dx,
  input  logic signed [DIF_W-1:0] dy,
  output logic                    busy,
  output logic signed [ANG_W-1:0] bearing
);

  logic signed [XY_W-1:0] x, y;
  logic signed [Z_W-1:0]  z;
  logic [STEP_W-1:0]      step;
  logic                   zero_vec;
  logic signed [XY_W-1:0] x_in, y_in, xs, ys;
  logic signed [Z_W-1:0]  z_round;

  assign x_in = XY_W'(dx) <<< 24;
  assign y_in = XY_W'(dy) <<< 24;
  assign xs   = x >>> step;
  assign ys   = y >>> step;

  // Round to Q3.12: add half an output step, then shift.
  assign z_round = z + 34'sd131072;
  assign bearing = zero_vec ? '0 : z_round[Z_W-1 -: ANG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy     <= (dx != '0) || (dy != '0);
      zero_vec <= (dx == '0) && (dy == '0);
      step     <= '0;
      // Left half plane: turn by a quarter first so the rotations converge.
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x <= y_in;
          y <= -x_in;
          z <= HALF_PI_Q30;
        end else begin
          x <= -y_in;
          y <= x_in;
          z <= -HALF_PI_Q30;
        end
      end else begin
        x <= x_in;
        y <= y_in;
        z <= '0;
      end
    end else if (busy) begin
      if (y >= 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_entry(5'(step));
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_entry(5'(step));
      end
      if (32'(step) == CORDIC_STEPS - 1 || 32'(step) == ATAN_LEN - 1) begin
        busy <= 1'b0;
      end
      step <= step + 1'b1;
    end
  end

endmodule

[rtl/polar_waypoint_follow_controller.sv]
// Channel  Direction  Handshake          Word
// req      in         req_valid/stall    req_word_t: load a waypoint or give a pose
// cmd      out        cmd_valid/stall    cmd_word_t: speed and turn commands
// apb      in/out     psel/penable/...   seven control registers, 32 bit data
//
// A load word is written to the table when it is accepted. A pose word runs fetch,
// difference, squares, the 25-step square root beside the bearing rotation, the
// angle wrap until both angles are in range, the gain products and the result. A
// pose past the last waypoint goes straight to the result. Reset clears the index,
// the registers and the handshake state, not the waypoint table. The result waits
// in the cmd register while cmd_stall is high, and a new request can be accepted.
module polar_waypoint_follow_controller
  import pwf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_word_t   req,
  output logic        cmd_valid,
  input  logic        cmd_stall,
  output cmd_word_t   cmd,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Control registers.
  logic signed [15:0] gain_distance, gain_bearing, gain_final_heading;
  logic [22:0]        arrive_radius;
  logic signed [23:0] linear_limit, angular_limit;
  logic [IDX_W-1:0]   waypoint_count;
  logic [2:0]         reg_sel;
  logic               reg_write;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[4:2];
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_distance      <= 16'sd1229;
      gain_bearing       <= 16'sd8192;
      gain_final_heading <= -16'sd6144;
      arrive_radius      <= 23'd819;
      linear_limit       <= 24'sd2048;
      angular_limit      <= 24'sd4096;
      waypoint_count     <= '0;
    end else if (reg_write) begin
      unique case (reg_sel)
        REG_GAIN_DIST:    gain_distance      <= pwdata[15:0];
        REG_GAIN_BEAR:    gain_bearing       <= pwdata[15:0];
        REG_GAIN_HEAD:    gain_final_heading <= pwdata[15:0];
        REG_ARRIVE_RAD:   arrive_radius      <= pwdata[22:0];
        REG_LINEAR_LIM:   linear_limit       <= pwdata[23:0];
        REG_ANGULAR_LIM:  angular_limit      <= pwdata[23:0];
        REG_WAYPOINT_CNT: waypoint_count     <= pwdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GAIN_DIST:    prdata = {16'd0, gain_distance};
      REG_GAIN_BEAR:    prdata = {16'd0, gain_bearing};
      REG_GAIN_HEAD:    prdata = {16'd0, gain_final_heading};
      REG_ARRIVE_RAD:   prdata = {9'd0, arrive_radius};
      REG_LINEAR_LIM:   prdata = {8'd0, linear_limit};
      REG_ANGULAR_LIM:  prdata = {8'd0, angular_limit};
      REG_WAYPOINT_CNT: prdata = 32'(waypoint_count);
      default:          prdata = '0;
    endcase
  end

  // Index of the waypoint being approached.
  logic [IDX_W-1:0] current_index;

  // Waypoint table: one word per entry holding x, y and heading.
  localparam int WP_W = 2 * POS_W + ANG_W;

  logic [WP_W-1:0]   wp_mem [WAYPOINT_DEPTH];
  logic [WP_W-1:0]   wp_rd;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;

  assign wr_addr = ADDR_W'(req.entry_index);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wp_mem[wr_addr] <= {req.pos_x, req.pos_y, req.heading};
    end
    wp_rd <= wp_mem[ADDR_W'(current_index)];
  end

  // Sequencer and datapath registers.
  state_t state, state_next;

  logic signed [POS_W-1:0] px, py;
  logic signed [ANG_W-1:0] hd, hwp;
  logic signed [DIF_W-1:0] dx, dy;
  logic [SQ_W-1:0]         sumsq;
  logic signed [51:0]      prod;
  logic signed [19:0]      alpha, beta;
  logic signed [41:0]      vacc;
  logic signed [31:0]      wacc;
  logic                    fin;

  logic             req_take, pose_done, cmd_free;
  logic             cordic_go, root_go, cordic_busy, root_busy;
  logic [RHO_W-1:0] rho;
  logic signed [ANG_W-1:0] bearing;
  logic signed [25:0] mul_a, mul_b;

  assign req_take = req_valid && !req_stall;
  assign cmd_free = !cmd_valid || !cmd_stall;

  // Effective count is limited to the table depth.
  always_comb begin
    if (32'(waypoint_count) > WAYPOINT_DEPTH) begin
      pose_done = 32'(current_index) >= WAYPOINT_DEPTH;
    end else begin
      pose_done = current_index >= waypoint_count;
    end
  end

  pwf_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_go),
    .dx      (dx),
    .dy      (dy),
    .busy    (cordic_busy),
    .bearing (bearing)
  );

  pwf_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_go),
    .radicand (sumsq),
    .busy     (root_busy),
    .root     (rho)
  );

  // Angle wrap: one add or subtract of 2*pi per cycle on each angle until both are in range.
  logic alpha_ok, beta_ok;

  assign alpha_ok = (alpha <= 20'(PI_Q12)) && (alpha > -20'(PI_Q12));
  assign beta_ok  = (beta <= 20'(PI_Q12)) && (beta > -20'(PI_Q12));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_take && req.op == OP_POSE) begin
          state_next = pose_done ? ST_RESULT : ST_FETCH;
        end
      end
      ST_FETCH:   state_next = ST_DIFF;
      ST_DIFF:    state_next = ST_SQX;
      ST_SQX:     state_next = ST_SQY;
      ST_SQY:     state_next = ST_SUMSQ;
      ST_SUMSQ:   state_next = ST_ROOT_GO;
      ST_ROOT_GO: state_next = ST_SOLVE;
      ST_SOLVE: begin
        if (!cordic_busy && !root_busy) begin
          state_next = ST_ANGLE;
        end
      end
      ST_ANGLE: state_next = ST_WRAP;
      ST_WRAP: begin
        if (alpha_ok && beta_ok) begin
          state_next = ST_MRHO;
        end
      end
      ST_MRHO:   state_next = ST_MALPHA;
      ST_MALPHA: state_next = ST_MBETA;
      ST_MBETA:  state_next = ST_SUMW;
      ST_SUMW:   state_next = ST_RESULT;
      ST_RESULT: begin
        if (cmd_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    mem_we    = 1'b0;
    cordic_go = 1'b0;
    root_go   = 1'b0;
    mul_a     = 26'(dx);
    mul_b     = 26'(dx);
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        mem_we    = req_valid && req.op == OP_LOAD &&
                    32'(req.entry_index) < WAYPOINT_DEPTH;
      end
      ST_SQY: begin
        mul_a = 26'(dy);
        mul_b = 26'(dy);
      end
      ST_SUMSQ:   cordic_go = 1'b1;
      ST_ROOT_GO: root_go = 1'b1;
      ST_MRHO: begin
        mul_a = 26'(gain_distance);
        mul_b = 26'(rho);
      end
      ST_MALPHA: begin
        mul_a = 26'(gain_bearing);
        mul_b = 26'(alpha);
      end
      ST_MBETA: begin
        mul_a = 26'(gain_final_heading);
        mul_b = 26'(beta);
      end
      default: ;
    endcase
  end

  // Bearing error before the wrap, and heading error taken against it.
  logic signed [19:0] alpha_raw, beta_raw;

  assign alpha_raw = 20'(bearing) - 20'(hd);
  assign beta_raw  = 20'(hwp) - 20'(hd) - alpha_raw;

  // Command clamp: limit from above, then saturate to the field range.
  logic signed [41:0] v_shift, w_shift, v_lim, w_lim;
  logic signed [23:0] v_sat, w_sat;

  assign v_shift = vacc >>> 12;
  assign w_shift = 42'(wacc) >>> 12;
  assign v_lim   = (v_shift > 42'(linear_limit)) ? 42'(linear_limit) : v_shift;
  assign w_lim   = (w_shift > 42'(angular_limit)) ? 42'(angular_limit) : w_shift;

  always_comb begin
    if (v_lim > 42'sd8388607) begin
      v_sat = 24'sh7FFFFF;
    end else if (v_lim < -42'sd8388608) begin
      v_sat = 24'sh800000;
    end else begin
      v_sat = v_lim[23:0];
    end
    if (w_lim > 42'sd8388607) begin
      w_sat = 24'sh7FFFFF;
    end else if (w_lim < -42'sd8388608) begin
      w_sat = 24'sh800000;
    end else begin
      w_sat = w_lim[23:0];
    end
  end

  logic arrived;

  assign arrived = 32'(rho) < 32'(arrive_radius);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      current_index <= '0;
      cmd_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RESULT && cmd_free) begin
        cmd_valid <= 1'b1;
        if (!fin && arrived) begin
          current_index <= current_index + 1'b1;
        end
      end else if (cmd_valid && !cmd_stall) begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      ST_IDLE: begin
        px  <= req.pos_x;
        py  <= req.pos_y;
        hd  <= req.heading;
        fin <= pose_done;
      end
      ST_DIFF: begin
        dx  <= DIF_W'($signed(wp_rd[WP_W-1 -: POS_W])) - DIF_W'(px);
        dy  <= DIF_W'($signed(wp_rd[ANG_W +: POS_W])) - DIF_W'(py);
        hwp <= wp_rd[ANG_W-1:0];
      end
      ST_SUMSQ: sumsq <= sumsq + prod[SQ_W-1:0];
      ST_ANGLE: begin
        alpha <= alpha_raw;
        beta  <= beta_raw;
      end
      ST_WRAP: begin
        if (alpha > 20'(PI_Q12)) begin
          alpha <= alpha - 20'(TWO_PI_Q12);
        end else if (alpha <= -20'(PI_Q12)) begin
          alpha <= alpha + 20'(TWO_PI_Q12);
        end
        if (beta > 20'(PI_Q12)) begin
          beta <= beta - 20'(TWO_PI_Q12);
        end else if (beta <= -20'(PI_Q12)) begin
          beta <= beta + 20'(TWO_PI_Q12);
        end
      end
      ST_MALPHA: vacc <= prod[41:0];
      ST_MBETA:  wacc <= prod[31:0];
      ST_SUMW:   wacc <= wacc + prod[31:0];
      ST_RESULT: begin
        if (cmd_free) begin
          if (fin) begin
            cmd.v_cmd        <= '0;
            cmd.w_cmd        <= '0;
            cmd.target_index <= current_index;
            cmd.reached      <= 1'b0;
            cmd.finished     <= 1'b1;
          end else begin
            cmd.v_cmd        <= v_sat;
            cmd.w_cmd        <= w_sat;
            cmd.target_index <= arrived ? current_index + 1'b1 : current_index;
            cmd.reached      <= arrived;
            cmd.finished     <= 1'b0;
          end
        end
      end
      default: ;
    endcase
    // The first square lands while its successor is being formed.
    if (state == ST_SQY) begin
      sumsq <= prod[SQ_W-1:0];
    end
  end

endmodule
